FILE: hw/rtl/grwc_pkg.sv
// Package for the grid run window counter: sizes, constants, register codes,
// the per-cell control bundle and the clamp helpers.
// No dependencies.
`default_nettype none

package grwc_pkg;

   localparam int MAX_COLS = 64;
   localparam int MAX_RUN  = 64;

   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int WID_W = $clog2(MAX_COLS + 1);
   localparam int RUN_W = $clog2(MAX_RUN + 1);
   localparam int CFG_W = 7;
   localparam int CNT_W = 16;

   localparam logic [7:0]       TARGET_CELL = 8'd88;
   localparam logic [CNT_W-1:0] COUNT_MAX   = {CNT_W{1'b1}};

   typedef enum logic [1:0] {
      REG_ORIENTATION = 2'd0,
      REG_RUN_LENGTH  = 2'd1,
      REG_ROW_WIDTH   = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic             advance;
      logic             clear;
      logic             hit;
      logic [RUN_W-1:0] limit;
      logic [WID_W-1:0] width;
   } cell_ctl_type;

   function automatic logic [RUN_W-1:0] eff_run(input logic [CFG_W-1:0] r);
      logic [RUN_W-1:0] res;
      if (r == '0) begin
         res = RUN_W'(1);
      end else if (int'(r) > MAX_RUN) begin
         res = RUN_W'(MAX_RUN);
      end else begin
         res = RUN_W'(r);
      end
      return res;
   endfunction

   function automatic logic [WID_W-1:0] eff_width(input logic [CFG_W-1:0] w);
      logic [WID_W-1:0] res;
      if (w == '0) begin
         res = WID_W'(1);
      end else if (int'(w) > MAX_COLS) begin
         res = WID_W'(MAX_COLS);
      end else begin
         res = WID_W'(w);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/grwc_cell.sv
// One column cell: holds the column's run of target cells and the column
// position token, which it hands to its right neighbor on every beat.
// Depends on grwc_pkg.
`default_nettype none

module grwc_cell (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire grwc_pkg::cell_ctl_type    ctl,
   input  wire logic [grwc_pkg::COL_W-1:0] col_index,
   input  wire logic                      token_in,
   output logic                           token_out,
   output logic                           wrap_out,
   output logic                           reach_out
);

   logic                          token_ff, token_in_d;
   logic [grwc_pkg::RUN_W-1:0]    run_ff, run_in;
   logic [grwc_pkg::RUN_W:0]      run_inc;
   logic                          is_first, is_end;

   assign is_first = (col_index == '0);
   assign is_end   = ((grwc_pkg::WID_W + 1)'(col_index) + 1'b1)
                     >= (grwc_pkg::WID_W + 1)'(ctl.width);
   assign run_inc  = (grwc_pkg::RUN_W + 1)'(run_ff) + 1'b1;

   assign token_out = token_ff;
   assign wrap_out  = token_ff & is_end;
   assign reach_out = token_ff & ctl.hit & (run_inc >= (grwc_pkg::RUN_W + 1)'(ctl.limit));

   always_comb begin
      token_in_d = token_ff;
      run_in     = run_ff;
      if (ctl.advance) begin
         token_in_d = ctl.clear ? is_first : token_in;
         if (ctl.clear) begin
            run_in = '0;
         end else if (token_ff) begin
            if (!ctl.hit) begin
               run_in = '0;
            end else if (run_ff >= ctl.limit) begin
               run_in = ctl.limit;
            end else begin
               run_in = run_inc[grwc_pkg::RUN_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= is_first;
         run_ff   <= '0;
      end else begin
         token_ff <= token_in_d;
         run_ff   <= run_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/grid_run_window_counter_top.sv
// A grid's count appears on rsp_ in the cycle after its last cell's beat.
// Throughput: one cell per cycle unless a result waits on rsp_ready; each beat
// runs one column cell update, the row run update and the total increment at once.
// Reset: synchronous; clears all runs, the total and the result valid flag, puts
// the column token at column zero and loads the register defaults.
`default_nettype none

module grid_run_window_counter_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_cell_req,
   input  wire logic        req_last_cell,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_window_count,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int NC = grwc_pkg::MAX_COLS;
   localparam int RW = grwc_pkg::RUN_W;

   logic                         orient_ff;
   logic [grwc_pkg::CFG_W-1:0]   run_len_ff, row_width_ff;
   grwc_pkg::reg_index_type      reg_sel;
   logic                         csr_write;

   logic                         accept, hit;
   grwc_pkg::cell_ctl_type       ctl;
   logic [NC-1:0]                token, wrap, reach, token_in;

   logic [RW-1:0]                row_run_ff, row_run_in, row_prev;
   logic [RW:0]                  row_inc;
   logic                         row_reach, counted;
   logic [grwc_pkg::CNT_W-1:0]   total_ff, total_in, total_next;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [grwc_pkg::CNT_W-1:0]   rsp_count_ff, rsp_count_in;

   // configuration port
   assign pready    = 1'b1;
   assign reg_sel   = grwc_pkg::reg_index_type'(paddr[3:2]);
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      prdata = '0;
      case (reg_sel)
         grwc_pkg::REG_ORIENTATION: prdata = 32'(orient_ff);
         grwc_pkg::REG_RUN_LENGTH:  prdata = 32'(run_len_ff);
         grwc_pkg::REG_ROW_WIDTH:   prdata = 32'(row_width_ff);
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         orient_ff    <= 1'b0;
         run_len_ff   <= grwc_pkg::CFG_W'(1);
         row_width_ff <= grwc_pkg::CFG_W'(64);
      end else if (csr_write) begin
         case (reg_sel)
            grwc_pkg::REG_ORIENTATION: orient_ff    <= pwdata[0];
            grwc_pkg::REG_RUN_LENGTH:  run_len_ff   <= pwdata[grwc_pkg::CFG_W-1:0];
            grwc_pkg::REG_ROW_WIDTH:   row_width_ff <= pwdata[grwc_pkg::CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // beat control
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;
   assign hit       = (req_cell_req == grwc_pkg::TARGET_CELL);

   assign ctl.advance = accept;
   assign ctl.clear   = req_last_cell;
   assign ctl.hit     = hit;
   assign ctl.limit   = grwc_pkg::eff_run(run_len_ff);
   assign ctl.width   = grwc_pkg::eff_width(row_width_ff);

   // column cell chain
   for (genvar i = 0; i < NC; i++) begin : g_col
      if (i == 0) begin : g_head
         assign token_in[i] = |wrap;
      end else begin : g_link
         assign token_in[i] = token[i-1] & ~wrap[i-1];
      end

      grwc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .col_index (grwc_pkg::COL_W'(i)),
         .token_in  (token_in[i]),
         .token_out (token[i]),
         .wrap_out  (wrap[i]),
         .reach_out (reach[i])
      );
   end

   // row run and total
   assign row_prev  = token[0] ? '0 : row_run_ff;
   assign row_inc   = (RW + 1)'(row_prev) + 1'b1;
   assign row_reach = hit & (row_inc >= (RW + 1)'(ctl.limit));
   assign counted   = orient_ff ? (|reach) : row_reach;
   assign total_next = (counted && (total_ff != grwc_pkg::COUNT_MAX)) ?
                       total_ff + 1'b1 : total_ff;

   always_comb begin
      if (!hit) begin
         row_run_in = '0;
      end else if (row_prev >= ctl.limit) begin
         row_run_in = ctl.limit;
      end else begin
         row_run_in = row_inc[RW-1:0];
      end
   end

   always_comb begin
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_count_in = rsp_count_ff;
      if (accept) begin
         total_in = req_last_cell ? '0 : total_next;
         if (req_last_cell) begin
            rsp_valid_in = 1'b1;
            rsp_count_in = total_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_run_ff   <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            row_run_ff <= req_last_cell ? '0 : row_run_in;
         end
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_token_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(token))
      else $error("column token not one-hot");

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_cell) |=> rsp_valid)
      else $error("last cell beat without result");

   a_last_rewinds: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_cell) |=> (token[0] && total_ff == '0 && row_run_ff == '0))
      else $error("state not cleared after last cell");
`endif

endmodule

`default_nettype wire
